### src/raster_band_pad_and_gray_convert_unit_defines.svh
// Assertion macros used by the checker of the band padding unit.
`ifndef RASTER_BAND_PAD_AND_GRAY_CONVERT_UNIT_DEFINES_SVH
`define RASTER_BAND_PAD_AND_GRAY_CONVERT_UNIT_DEFINES_SVH

// Same-cycle implication, skipped while dis is high.
`define RBPGC_ASSERT_NOW(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, skipped while dis is high.
`define RBPGC_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### src/rbpgc_pkg.sv
`default_nettype none

package rbpgc_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_PAGE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_PAGE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_BAND_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_BAND_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_LEFT_OFFSET = 3'd4;
    localparam logic [2:0] CFG_TOP_OFFSET  = 3'd5;
    localparam logic [2:0] CFG_COLOR_MODE  = 3'd6;

    localparam int CFG_DATA_W = 15;
    localparam int RUN_W      = 28;

    typedef logic [2:0]            t_cfg_index;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [RUN_W-1:0]      t_run;
    typedef logic [7:0]            t_sample;

    // Color modes; the unused code converts like the luma mode
    localparam logic [1:0] MODE_GRAY = 2'd0;
    localparam logic [1:0] MODE_RGB  = 2'd1;
    localparam logic [1:0] MODE_LUMA = 2'd2;

    // Register reset values
    localparam logic [13:0] RST_PAGE_WIDTH  = 14'd5100;
    localparam logic [14:0] RST_PAGE_HEIGHT = 15'd6600;
    localparam logic [13:0] RST_BAND_WIDTH  = 14'd5100;
    localparam logic [14:0] RST_BAND_HEIGHT = 15'd6600;
    localparam logic [1:0]  RST_COLOR_MODE  = MODE_RGB;

    // Rec.601 luma weights, sum of 256
    localparam logic [15:0] LUMA_R = 16'd77;
    localparam logic [15:0] LUMA_G = 16'd151;
    localparam logic [15:0] LUMA_B = 16'd28;

    localparam t_sample WHITE = 8'hFF;

endpackage

`default_nettype wire

### src/raster_band_pad_and_gray_convert_unit.sv
// Path: a pixel beat that is taken passes the stage 1, stage 2 and output registers before its result beats show.
// Throughput: one pixel beat per cycle while the output is ready and no register write is settling;
// a pixel yields one to three result beats, and the output register hands out one result
// beat per cycle, so a pixel that opens a band row with a margin takes the output for a gap beat and its pixel beat.
// Reset: counters return to the band origin, registers take their defaults, and input
// is held off after reset and after every register write until the settle counter runs out.
`default_nettype none

module raster_band_pad_and_gray_convert_unit
    import rbpgc_pkg::*;
#(
    parameter int MAX_WIDTH  = 8192,
    parameter int MAX_HEIGHT = 16384
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire t_cfg_index  i_cfg_index,
    input  wire t_cfg_data   i_cfg_data,
    // pixel input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_sample     i_red_or_gray,
    input  wire t_sample     i_green_in,
    input  wire t_sample     i_blue_in,
    // result output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_sample          o_chan_a,
    output t_sample          o_chan_b,
    output t_sample          o_chan_c,
    output t_run             o_run_length,
    output logic             o_page_end
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int PRW = WW + HW;
    localparam logic [1:0] SETTLE = 2'd3;

    function automatic logic [31:0] fit_dim(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        r = v;
        if (v == 32'd0) begin
            r = 32'd1;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // ---------------- configuration registers ----------------
    logic [13:0] r_page_width, r_band_width;
    logic [14:0] r_page_height, r_band_height;
    logic [12:0] r_left_offset;
    logic [13:0] r_top_offset;
    logic [1:0]  r_color_mode;
    logic [1:0]  r_settle;

    // Write a register, and hold input off while derived geometry settles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_width  <= RST_PAGE_WIDTH;
            r_page_height <= RST_PAGE_HEIGHT;
            r_band_width  <= RST_BAND_WIDTH;
            r_band_height <= RST_BAND_HEIGHT;
            r_left_offset <= '0;
            r_top_offset  <= '0;
            r_color_mode  <= RST_COLOR_MODE;
            r_settle      <= SETTLE;
        end else begin
            if (i_cfg_wr_en) begin
                r_settle <= SETTLE;
                unique case (i_cfg_index)
                    CFG_PAGE_WIDTH:  r_page_width  <= i_cfg_data[13:0];
                    CFG_PAGE_HEIGHT: r_page_height <= i_cfg_data[14:0];
                    CFG_BAND_WIDTH:  r_band_width  <= i_cfg_data[13:0];
                    CFG_BAND_HEIGHT: r_band_height <= i_cfg_data[14:0];
                    CFG_LEFT_OFFSET: r_left_offset <= i_cfg_data[12:0];
                    CFG_TOP_OFFSET:  r_top_offset  <= i_cfg_data[13:0];
                    CFG_COLOR_MODE:  r_color_mode  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    // ---------------- derived geometry ----------------
    logic [WW-1:0]  n_bw, n_pw, n_pw_fit, n_margin_w, n_left;
    logic [HW-1:0]  n_bh, n_ph, n_ph_fit, n_margin_h, n_top;
    logic [WW-1:0]  r_bw, r_pw, r_left, r_margin;
    logic [HW-1:0]  r_bh, r_ph, r_top;
    logic [PRW-1:0] r_total, r_kend;

    // Fit sizes, grow the page to the band, clamp offsets
    always_comb begin
        n_bw       = WW'(fit_dim(32'(r_band_width), 32'(MAX_WIDTH)));
        n_bh       = HW'(fit_dim(32'(r_band_height), 32'(MAX_HEIGHT)));
        n_pw_fit   = WW'(fit_dim(32'(r_page_width), 32'(MAX_WIDTH)));
        n_ph_fit   = HW'(fit_dim(32'(r_page_height), 32'(MAX_HEIGHT)));
        n_pw       = (n_pw_fit < n_bw) ? n_bw : n_pw_fit;
        n_ph       = (n_ph_fit < n_bh) ? n_bh : n_ph_fit;
        n_margin_w = n_pw - n_bw;
        n_margin_h = n_ph - n_bh;
        n_left     = (32'(r_left_offset) > 32'(n_margin_w)) ? n_margin_w
                                                             : WW'(r_left_offset);
        n_top      = (32'(r_top_offset) > 32'(n_margin_h)) ? n_margin_h
                                                            : HW'(r_top_offset);
    end

    // Register the geometry; page area is registered from the registered sizes, and end offset from the registered area
    always_ff @(posedge i_clk) begin
        r_bw     <= n_bw;
        r_bh     <= n_bh;
        r_pw     <= n_pw;
        r_ph     <= n_ph;
        r_left   <= n_left;
        r_top    <= n_top;
        r_margin <= n_margin_w;
        r_total  <= PRW'(r_pw) * PRW'(r_ph);
        r_kend   <= r_total - PRW'(1) - PRW'(r_left);
    end

    // ---------------- handshake chain ----------------
    logic       r_s1_valid, r_s2_valid;
    logic [2:0] r_o_mask;
    logic       o_single, s3_take, s2_free, s1_free, in_beat, out_beat;

    assign o_single   = (r_o_mask != 3'd0) && ((r_o_mask & (r_o_mask - 3'd1)) == 3'd0);
    assign o_out_valid = (r_o_mask != 3'd0);
    assign out_beat   = o_out_valid && i_out_ready;
    assign s3_take    = !o_out_valid || (i_out_ready && o_single);
    assign s2_free    = !r_s2_valid || s3_take;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_in_ready = s1_free && (r_settle == 2'd0);
    assign in_beat    = i_in_valid && o_in_ready;

    // ---------------- stage 1: band position ----------------
    logic [CW-1:0] r_col, n_col, s1_col_use;
    logic [RW-1:0] r_row, n_row, s1_row_use;
    logic [WW-1:0] s1_col_inc;
    logic [HW-1:0] s1_row_inc;
    logic          s1_first, s1_rowstart, s1_last;

    // Fold stale counters to the origin and advance in raster order
    always_comb begin
        s1_col_use  = (WW'(r_col) >= r_bw) ? '0 : r_col;
        s1_row_use  = (HW'(r_row) >= r_bh) ? '0 : r_row;
        s1_col_inc  = WW'(s1_col_use) + WW'(1);
        s1_row_inc  = HW'(s1_row_use) + HW'(1);
        s1_first    = (s1_col_use == '0) && (s1_row_use == '0);
        s1_rowstart = (s1_col_use == '0);
        s1_last     = (WW'(s1_col_use) == r_bw - WW'(1)) &&
                      (HW'(s1_row_use) == r_bh - HW'(1));
        n_col       = s1_col_use;
        n_row       = s1_row_use;
        if (s1_col_inc >= r_bw) begin
            n_col = '0;
            n_row = (s1_row_inc >= r_bh) ? '0 : RW'(s1_row_inc);
        end else begin
            n_col = CW'(s1_col_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_beat) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    t_sample       r_s1_a, r_s1_b, r_s1_c;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic          r_s1_first, r_s1_rowstart, r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_a        <= i_red_or_gray;
            r_s1_b        <= i_green_in;
            r_s1_c        <= i_blue_in;
            r_s1_col      <= s1_col_use;
            r_s1_row      <= s1_row_use;
            r_s1_first    <= s1_first;
            r_s1_rowstart <= s1_rowstart;
            r_s1_last     <= s1_last;
        end
    end

    // ---------------- stage 2: row product and color ----------------
    logic [HW:0]   s2_top_row;
    logic [WW:0]   s2_lc;
    logic [15:0]   s2_luma;
    t_sample       s2_a, s2_b, s2_c;

    always_comb begin
        s2_top_row = {1'b0, r_top} + (HW+1)'(r_s1_row);
        s2_lc      = {1'b0, r_left} + (WW+1)'(r_s1_col);
        s2_luma    = 16'(r_s1_a) * LUMA_R + 16'(r_s1_b) * LUMA_G + 16'(r_s1_c) * LUMA_B;
        case (r_color_mode)
            MODE_GRAY: begin
                s2_a = r_s1_a;
                s2_b = r_s1_a;
                s2_c = r_s1_a;
            end
            MODE_RGB: begin
                s2_a = r_s1_a;
                s2_b = r_s1_b;
                s2_c = r_s1_c;
            end
            default: begin
                s2_a = s2_luma[15:8];
                s2_b = s2_luma[15:8];
                s2_c = s2_luma[15:8];
            end
        endcase
    end

    t_sample        r_s2_a, r_s2_b, r_s2_c;
    logic [PRW-1:0] r_s2_prod, r_s2_lc, r_s2_kl;
    logic           r_s2_first, r_s2_rowstart, r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_valid) begin
            r_s2_a        <= s2_a;
            r_s2_b        <= s2_b;
            r_s2_c        <= s2_c;
            r_s2_prod     <= PRW'(s2_top_row[HW-1:0]) * PRW'(r_pw);
            r_s2_lc       <= PRW'(s2_lc[WW-1:0]);
            r_s2_kl       <= r_kend - PRW'(r_s1_col);
            r_s2_first    <= r_s1_first;
            r_s2_rowstart <= r_s1_rowstart;
            r_s2_last     <= r_s1_last;
        end
    end

    // ---------------- stage 3: runs and output register ----------------
    logic [PRW-1:0] s3_pos, s3_gap, s3_trail;
    logic           s3_gap_nz, s3_trail_nz;

    // Leading gap, trailing margin and which results exist
    always_comb begin
        s3_pos = r_s2_prod + r_s2_lc;
        if (r_s2_first) begin
            s3_gap = s3_pos;
        end else if (r_s2_rowstart) begin
            s3_gap = PRW'(r_margin);
        end else begin
            s3_gap = '0;
        end
        s3_trail    = r_s2_kl - r_s2_prod;
        s3_gap_nz   = (s3_gap != '0);
        s3_trail_nz = r_s2_last && (s3_trail != '0);
    end

    t_sample r_o_a, r_o_b, r_o_c;
    t_run    r_o_gap, r_o_trail;
    logic    r_o_pix_end;

    // Load a new item when the last beat leaves, else drop the beat just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_mask <= 3'd0;
        end else if (s3_take) begin
            r_o_mask <= r_s2_valid ? {s3_trail_nz, 1'b1, s3_gap_nz} : 3'd0;
        end else if (out_beat) begin
            r_o_mask <= r_o_mask & (r_o_mask - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_take && r_s2_valid) begin
            r_o_a       <= r_s2_a;
            r_o_b       <= r_s2_b;
            r_o_c       <= r_s2_c;
            r_o_gap     <= RUN_W'(s3_gap);
            r_o_trail   <= RUN_W'(s3_trail);
            r_o_pix_end <= r_s2_last && !s3_trail_nz;
        end
    end

    // Present the lowest pending result
    always_comb begin
        if (r_o_mask[0]) begin
            o_chan_a     = WHITE;
            o_chan_b     = WHITE;
            o_chan_c     = WHITE;
            o_run_length = r_o_gap;
            o_page_end   = 1'b0;
        end else if (r_o_mask[1]) begin
            o_chan_a     = r_o_a;
            o_chan_b     = r_o_b;
            o_chan_c     = r_o_c;
            o_run_length = RUN_W'(1);
            o_page_end   = r_o_pix_end;
        end else begin
            o_chan_a     = WHITE;
            o_chan_b     = WHITE;
            o_chan_c     = WHITE;
            o_run_length = r_o_trail;
            o_page_end   = 1'b1;
        end
    end

endmodule

`default_nettype wire

### src/rbpgc_checker.sv
`default_nettype none
`include "raster_band_pad_and_gray_convert_unit_defines.svh"

module rbpgc_checker
    import rbpgc_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_cfg_wr_en,
    input wire logic    o_in_ready,
    input wire logic    o_out_valid,
    input wire logic    i_out_ready,
    input wire t_sample o_chan_a,
    input wire t_sample o_chan_b,
    input wire t_sample o_chan_c,
    input wire t_run    o_run_length,
    input wire logic    o_page_end
);

    logic               pixel_shown, out_stall;
    logic [3*8+RUN_W:0] shown_beat;

    // Name the conditions the properties look at
    assign pixel_shown = o_out_valid && (o_chan_a != WHITE);
    assign out_stall   = o_out_valid && !i_out_ready;
    assign shown_beat  = {o_chan_a, o_chan_b, o_chan_c, o_run_length, o_page_end};

    // Reset empties the output
    `RBPGC_ASSERT_NEXT(a_reset_clears_out, i_clk, 1'b0, !i_rst_n, !o_out_valid)

    // A register write holds input off in the following cycle
    `RBPGC_ASSERT_NEXT(a_cfg_blocks_in, i_clk, !i_rst_n, i_cfg_wr_en, !o_in_ready)

    // Any beat whose first channel is not white is a single band pixel
    `RBPGC_ASSERT_NOW(a_pixel_run_one, i_clk, !i_rst_n, pixel_shown, o_run_length == RUN_W'(1))

    // A stalled result beat holds
    `RBPGC_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, out_stall, o_out_valid && $stable(shown_beat))

endmodule

bind raster_band_pad_and_gray_convert_unit rbpgc_checker u_rbpgc_checker (.*);

`default_nettype wire
